/* hw/rtl/gnm_pkg.sv */
// Shared types, constants and helper functions for the eight-neighbour mask block.
// No dependencies; every other file of the block takes names from here.
`default_nettype none
package gnm_pkg;

  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = 5;
  localparam int ROW_W      = 10;
  localparam int WCFG_W     = 6;
  localparam int HCFG_W     = 11;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;
  localparam int MASK_W     = 8;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;
  localparam int QDEPTH     = 4;
  localparam int QAW        = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 2'd1;

  // One queued transaction: row snapshots and the results it owes.
  typedef struct packed {
    logic [MAX_WIDTH-1:0] above;
    logic [MAX_WIDTH-1:0] middle;
    logic [MAX_WIDTH-1:0] incoming;
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;
    logic                 emit_prev;
    logic                 emit_lc;
    logic                 flush;
  } gnm_entry_t;

  function automatic logic [WCFG_W-1:0] eff_width(input logic [WCFG_W-1:0] w);
    logic [WCFG_W-1:0] res;
    res = w;
    if (w == '0) res = WCFG_W'(1);
    else if (w > WCFG_W'(MAX_WIDTH)) res = WCFG_W'(MAX_WIDTH);
    return res;
  endfunction

  function automatic logic [HCFG_W-1:0] eff_height(input logic [HCFG_W-1:0] h);
    logic [HCFG_W-1:0] res;
    res = h;
    if (h == '0) res = HCFG_W'(1);
    else if (h > HCFG_W'(MAX_HEIGHT)) res = HCFG_W'(MAX_HEIGHT);
    return res;
  endfunction

  // 3x3 window lookup around one column; outside columns count as occupied.
  function automatic logic [MASK_W-1:0] neighbours(
    input logic [MAX_WIDTH-1:0] up,
    input logic [MAX_WIDTH-1:0] mid,
    input logic [MAX_WIDTH-1:0] down,
    input logic [COL_W-1:0]     col,
    input logic [WCFG_W-1:0]    w
  );
    logic [MASK_W-1:0] m;
    logic              has_left;
    logic              has_right;
    logic [COL_W-1:0]  cl;
    logic [COL_W-1:0]  cr;
    m         = '0;
    has_left  = (col != '0);
    has_right = ({1'b0, col} + WCFG_W'(1)) < w;
    cl        = col - COL_W'(1);
    cr        = col + COL_W'(1);
    if (mid[col]) begin
      m[1] = up[col];
      m[6] = down[col];
      if (has_left) begin
        m[0] = up[cl];
        m[3] = mid[cl];
        m[5] = down[cl];
      end
      if (has_right) begin
        m[2] = up[cr];
        m[4] = mid[cr];
        m[7] = down[cr];
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/gnm_front.sv */
// Front end: accepts cells, keeps the row stores and counters, classifies work.
// Depends on gnm_pkg; feeds gnm_queue.
`default_nettype none
module gnm_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [gnm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [gnm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              acc,
  input  wire logic                              cell_free,
  output gnm_pkg::gnm_entry_t                    entry,
  output logic                                   push,
  output logic [gnm_pkg::WCFG_W-1:0]             eff_w
);

  logic [gnm_pkg::WCFG_W-1:0]    width_r;
  logic [gnm_pkg::HCFG_W-1:0]    height_r;
  logic [gnm_pkg::MAX_WIDTH-1:0] above_r, middle_r, incoming_r;
  logic [gnm_pkg::COL_W-1:0]     col_r;
  logic [gnm_pkg::ROW_W-1:0]     row_r;
  logic [gnm_pkg::MAX_WIDTH-1:0] incoming_nxt;
  logic [gnm_pkg::HCFG_W-1:0]    eff_h;
  logic                          last_col, last_cell, cfg_hit;

  assign eff_w     = gnm_pkg::eff_width(width_r);
  assign eff_h     = gnm_pkg::eff_height(height_r);
  assign last_col  = ({1'b0, col_r} + gnm_pkg::WCFG_W'(1)) >= eff_w;
  assign last_cell = last_col &&
                     (({1'b0, row_r} + gnm_pkg::HCFG_W'(1)) >= eff_h);
  assign cfg_hit   = cfg_wr_en && ((cfg_addr == gnm_pkg::REG_GRID_WIDTH) ||
                                   (cfg_addr == gnm_pkg::REG_GRID_HEIGHT));

  always_comb begin
    incoming_nxt        = incoming_r;
    incoming_nxt[col_r] = incoming_r[col_r] | cell_free;
    entry.above     = above_r;
    entry.middle    = middle_r;
    entry.incoming  = incoming_nxt;
    entry.col       = col_r;
    entry.row       = row_r;
    entry.emit_prev = (row_r != '0) && (col_r != '0);
    entry.emit_lc   = (row_r != '0) && last_col;
    entry.flush     = last_cell;
    push = acc && (entry.emit_prev || entry.emit_lc || entry.flush);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= gnm_pkg::WCFG_W'(8);
      height_r   <= gnm_pkg::HCFG_W'(8);
      above_r    <= '0;
      middle_r   <= '0;
      incoming_r <= '0;
      col_r      <= '0;
      row_r      <= '0;
    end else if (cfg_hit) begin
      if (cfg_addr == gnm_pkg::REG_GRID_WIDTH) begin
        width_r <= cfg_wdata[gnm_pkg::WCFG_W-1:0];
      end else begin
        height_r <= cfg_wdata;
      end
      above_r    <= '0;
      middle_r   <= '0;
      incoming_r <= '0;
      col_r      <= '0;
      row_r      <= '0;
    end else if (acc) begin
      if (last_cell) begin
        above_r    <= '0;
        middle_r   <= '0;
        incoming_r <= '0;
        col_r      <= '0;
        row_r      <= '0;
      end else if (last_col) begin
        above_r    <= middle_r;
        middle_r   <= incoming_nxt;
        incoming_r <= '0;
        col_r      <= '0;
        row_r      <= row_r + gnm_pkg::ROW_W'(1);
      end else begin
        incoming_r <= incoming_nxt;
        col_r      <= col_r + gnm_pkg::COL_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/gnm_queue.sv */
// Short register FIFO of classified transactions between front and back end.
// Depends on gnm_pkg for the entry type and depth.
`default_nettype none
module gnm_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire gnm_pkg::gnm_entry_t wr_entry,
  input  wire logic                pop,
  output gnm_pkg::gnm_entry_t      head,
  output logic                     full,
  output logic                     empty
);

  gnm_pkg::gnm_entry_t         mem_r [gnm_pkg::QDEPTH];
  logic [gnm_pkg::QAW-1:0]     wp_r, rp_r;
  logic [gnm_pkg::QAW:0]       cnt_r;

  assign full  = (cnt_r == (gnm_pkg::QAW+1)'(gnm_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + gnm_pkg::QAW'(1);
      if (pop)  rp_r <= rp_r + gnm_pkg::QAW'(1);
      if (push && !pop)      cnt_r <= cnt_r + (gnm_pkg::QAW+1)'(1);
      else if (pop && !push) cnt_r <= cnt_r - (gnm_pkg::QAW+1)'(1);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/gnm_back.sv */
// Back end: walks the results owed by the head transaction, one per cycle while
// the output is not stalled, into the output register. Depends on gnm_pkg.
`default_nettype none
module gnm_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire gnm_pkg::gnm_entry_t                head,
  input  wire logic                               empty,
  input  wire logic [gnm_pkg::WCFG_W-1:0]         eff_w,
  output logic                                    pop,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [gnm_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic                                    out_tlast,
  output logic                                    out_tuser
);

  logic                          prev_done_r, lc_done_r;
  logic [gnm_pkg::COL_W-1:0]     k_r;
  logic                          valid_r, last_r, done_r;
  logic [gnm_pkg::OUT_DATA_W-1:0] data_r;

  logic                          load;
  logic [gnm_pkg::COL_W-1:0]     cur_col;
  logic [gnm_pkg::ROW_W-1:0]     cur_row;
  logic [gnm_pkg::MAX_WIDTH-1:0] up, mid, down;
  logic                          cur_last, cur_frame, in_prev, in_lc;
  logic [gnm_pkg::MASK_W-1:0]    cur_mask;

  assign load = !empty && (!valid_r || out_tready);
  assign pop  = load && cur_last;

  always_comb begin
    in_prev   = head.emit_prev && !prev_done_r;
    in_lc     = head.emit_lc && !lc_done_r;
    up        = head.above;
    mid       = head.middle;
    down      = head.incoming;
    cur_row   = head.row - gnm_pkg::ROW_W'(1);
    cur_frame = 1'b0;
    priority if (in_prev) begin
      cur_col  = head.col - gnm_pkg::COL_W'(1);
      cur_last = !head.emit_lc && !head.flush;
    end else if (in_lc) begin
      cur_col  = head.col;
      cur_last = !head.flush;
    end else begin
      // flush the final row; the row below it is all occupied
      cur_col   = k_r;
      cur_row   = head.row;
      up        = head.middle;
      mid       = head.incoming;
      down      = '0;
      cur_last  = ({1'b0, k_r} + gnm_pkg::WCFG_W'(1)) >= eff_w;
      cur_frame = cur_last;
    end
    cur_mask = gnm_pkg::neighbours(up, mid, down, cur_col, eff_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_done_r <= 1'b0;
      lc_done_r   <= 1'b0;
      k_r         <= '0;
      valid_r     <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        if (cur_last) begin
          prev_done_r <= 1'b0;
          lc_done_r   <= 1'b0;
          k_r         <= '0;
        end else if (in_prev) begin
          prev_done_r <= 1'b1;
        end else if (in_lc) begin
          lc_done_r <= 1'b1;
        end else begin
          k_r <= k_r + gnm_pkg::COL_W'(1);
        end
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {1'b0, cur_mask, cur_row, cur_col};
      last_r <= cur_last;
      done_r <= cur_frame;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = done_r;

endmodule
`default_nettype wire

/* hw/rtl/grid_eight_neighbour_mask.sv */
// Eight-connected 3x3 neighbourhood masks over a raster stream of grid cells.
// A result passes from the front end through the queue into the output register.
// Throughput: one cell per cycle while the queue has room; one result per cycle
// out unless stalled; the row-end extra and w-result flush drain via the queue.
// Reset (rst_n low, synchronous): width 8, height 8, row stores and counters clear,
// queue and output register empty.
`default_nettype none
module grid_eight_neighbour_mask (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [gnm_pkg::IN_DATA_W-1:0]      in_tdata,   // [0] cell_free
  // result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [4:0] cell_col, [14:5] cell_row, [22:15] neighbour_mask, [23] zero
  output logic [gnm_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic                                    out_tlast,  // run_last
  output logic                                    out_tuser,  // frame_done
  // configuration writes: 0 grid_width, 1 grid_height
  input  wire logic                               cfg_wr_en,
  input  wire logic [gnm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [gnm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  gnm_pkg::gnm_entry_t          fe_entry, q_head;
  logic                         fe_push, q_full, q_empty, q_pop, acc;
  logic [gnm_pkg::WCFG_W-1:0]   eff_w;

  // Accept a cell whenever the queue has room; a cell that owes nothing
  // still advances the counters.
  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  // Front: row stores, counters, config registers, classification.
  gnm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .cell_free (in_tdata[0]),
    .entry     (fe_entry),
    .push      (fe_push),
    .eff_w     (eff_w)
  );

  // Queue: decouple cell intake from result emission.
  gnm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fe_push),
    .wr_entry (fe_entry),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back: emit each owed result through the output register.
  gnm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .empty      (q_empty),
    .eff_w      (eff_w),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for grid_eight_neighbour_mask: raster cells in, neighbour masks out.
// Depends on gnm_pkg for widths and register indexes; predicts every result in-bench.
module tb_top;
  import gnm_pkg::*;

  // Register indexes that the block does not decode; writes to them must be ignored.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int SETTLE_CYCLES = 8;    // covers the queue and output register plus queue slack
  localparam int HOLD_CYCLES   = 300;  // long receiver hold-off to back the block up
  localparam int REPORT_LIMIT  = 10;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [MASK_W-1:0] mask;
    logic              run_last;
    logic              frame_done;
  } cell_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [0] cell_free, [7:1] ignored by the block
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [4:0] col, [14:5] row, [22:15] mask, [23] zero
  logic                  out_tlast;  // run_last
  logic                  out_tuser;  // frame_done
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  grid_eight_neighbour_mask i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  logic [IN_DATA_W-1:0] cell_queue[$];     // cells waiting to be offered
  cell_result_t         mask_expect[$];    // predicted results, oldest first
  idle_mode_e           idle_mode = IDLE_NONE;
  bit                   in_taken  = 1'b0;  // set by the monitor when a cell transaction lands
  bit                   hold_req  = 1'b0;
  int                   hold_left = 0;
  int                   mismatches = 0;
  int                   cells_sent = 0;
  int                   results_checked = 0;
  int                   settings_used = 0;

  // Predictor copy of the configuration and the row stores.
  logic [WCFG_W-1:0]    width_reg;
  logic [HCFG_W-1:0]    height_reg;
  logic [MAX_WIDTH-1:0] row_hi;    // two rows up
  logic [MAX_WIDTH-1:0] row_mid;   // one row up
  logic [MAX_WIDTH-1:0] row_new;   // row being received
  int unsigned          col_at;
  int unsigned          row_at;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned cols_in_use();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned rows_in_use();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  // Free neighbours of column col in the middle row; off-grid neighbours stay 0.
  function automatic logic [MASK_W-1:0] window_mask(
    input logic [MAX_WIDTH-1:0] up,
    input logic [MAX_WIDTH-1:0] mid,
    input logic [MAX_WIDTH-1:0] down,
    input int unsigned          col,
    input int unsigned          w
  );
    logic [MASK_W-1:0] m;
    m = '0;
    if (!mid[col]) return m;
    m[1] = up[col];
    m[6] = down[col];
    if (col > 0) begin
      m[0] = up[col-1];
      m[3] = mid[col-1];
      m[5] = down[col-1];
    end
    if (col + 1 < w) begin
      m[2] = up[col+1];
      m[4] = mid[col+1];
      m[7] = down[col+1];
    end
    return m;
  endfunction

  function automatic cell_result_t make_result(int unsigned col, int unsigned row,
                                               logic [MASK_W-1:0] m);
    cell_result_t res;
    res.col        = col[COL_W-1:0];
    res.row        = row[ROW_W-1:0];
    res.mask       = m;
    res.run_last   = 1'b0;
    res.frame_done = 1'b0;
    return res;
  endfunction

  task automatic restart_grid();
    row_hi  = '0;
    row_mid = '0;
    row_new = '0;
    col_at  = 0;
    row_at  = 0;
  endtask

  // Work out every result one accepted cell causes and queue them in order.
  task automatic predict_cell(input logic free);
    int unsigned  w;
    int unsigned  h;
    int unsigned  c;
    int unsigned  r;
    bit           last_col;
    bit           last_cell;
    cell_result_t batch[$];
    w         = cols_in_use();
    h         = rows_in_use();
    c         = col_at;
    r         = row_at;
    last_col  = (c + 1 >= w);
    last_cell = last_col && (r + 1 >= h);
    if (free) row_new[c] = 1'b1;
    // The row above is complete once the cell below-right of it arrives.
    if (r >= 1) begin
      if (c >= 1) batch.push_back(make_result(c - 1, r - 1,
                                              window_mask(row_hi, row_mid, row_new, c - 1, w)));
      if (last_col) batch.push_back(make_result(c, r - 1,
                                                window_mask(row_hi, row_mid, row_new, c, w)));
    end
    if (last_cell) begin
      // Flush the bottom row; nothing lies below it.
      for (int k = 0; k < w; k++)
        batch.push_back(make_result(k, r, window_mask(row_mid, row_new, '0, k, w)));
      batch[$].frame_done = 1'b1;
      restart_grid();
    end else if (last_col) begin
      row_hi  = row_mid;
      row_mid = row_new;
      row_new = '0;
      col_at  = 0;
      row_at  = r + 1;
    end else begin
      col_at = c + 1;
    end
    if (batch.size() > 0) batch[$].run_last = 1'b1;
    foreach (batch[i]) mask_expect.push_back(batch[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled on the rising edge
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string field, input int unsigned exp_v,
                               input int unsigned act_v);
    if (mismatches < REPORT_LIMIT)
      $display("tb_top: mismatch on %s at %0t: expected %0d, got %0d",
               field, $realtime, exp_v, act_v);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    cell_result_t want;
    if (!rst_n) begin
      width_reg  = WCFG_W'(8);
      height_reg = HCFG_W'(8);
      restart_grid();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_GRID_WIDTH: begin
            width_reg = cfg_wdata[WCFG_W-1:0];
            restart_grid();
          end
          REG_GRID_HEIGHT: begin
            height_reg = cfg_wdata[HCFG_W-1:0];
            restart_grid();
          end
          default: ;  // unmapped index: no effect, frame carries on
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_cell(in_tdata[0]);
        cells_sent++;
        in_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        if (mask_expect.size() == 0) begin
          flag_mismatch("unexpected result, col", 0, out_tdata[4:0]);
        end else begin
          want = mask_expect.pop_front();
          results_checked++;
          if (out_tdata[4:0] !== want.col)   flag_mismatch("cell_col", want.col, out_tdata[4:0]);
          if (out_tdata[14:5] !== want.row)  flag_mismatch("cell_row", want.row, out_tdata[14:5]);
          if (out_tdata[22:15] !== want.mask)
            flag_mismatch("neighbour_mask", want.mask, out_tdata[22:15]);
          if (out_tdata[23] !== 1'b0)        flag_mismatch("tdata pad bit", 0, out_tdata[23]);
          if (out_tlast !== want.run_last)   flag_mismatch("run_last", want.run_last, out_tlast);
          if (out_tuser !== want.frame_done)
            flag_mismatch("frame_done", want.frame_done, out_tuser);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and receiver: everything changes on the falling edge
  // ---------------------------------------------------------------------------
  function automatic int send_idle_pct(idle_mode_e mode);
    case (mode)
      IDLE_SEND: return 72;
      IDLE_BOTH: return 7;
      default:   return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct(idle_mode_e mode);
    case (mode)
      IDLE_RECV: return 72;
      IDLE_BOTH: return 7;
      default:   return 0;
    endcase
  endfunction

  // Hold the current cell until it is taken, then offer the next one or idle.
  always @(negedge clk) begin : feed
    if (!in_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (cell_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct(idle_mode)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= cell_queue.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drain_side
    out_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct(idle_mode));
  end

  // Count down the long hold-off; the sender keeps offering throughout.
  always @(posedge clk) begin : backpressure
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_grid(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    settings_used++;
  endtask

  // Wait until every cell is taken and every result seen, then let the pipe settle.
  task automatic drain();
    while (cell_queue.size() != 0 || in_tvalid || mask_expect.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_cells(input int n, input int free_pct);
    logic [IN_DATA_W-1:0] d;
    repeat (n) begin
      d[IN_DATA_W-1:1] = $urandom();
      d[0]             = ($urandom_range(0, 99) < free_pct);
      cell_queue.push_back(d);
    end
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input int n, input idle_mode_e mode, input int free_pct);
    set_grid(w, h);
    idle_mode = mode;
    random_cells(n, free_pct);
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset geometry (8 x 8): a free top row, then half of row 1 with junk upper bits.
    repeat (8) cell_queue.push_back(8'h01);
    cell_queue.push_back(8'hA1);
    cell_queue.push_back(8'h40);
    cell_queue.push_back(8'hFF);
    cell_queue.push_back(8'h00);
    drain();
    // Unmapped register writes must leave the frame in progress untouched.
    write_reg(REG_SPARE_2, 11'h7FF);
    write_reg(REG_SPARE_3, 11'h000);
    cell_queue.push_back(8'h01);
    cell_queue.push_back(8'h01);
    cell_queue.push_back(8'hFE);
    cell_queue.push_back(8'h01);
    drain();

    // Zero width and height act as a 1 x 1 grid: every cell ends a frame.
    set_grid(11'd0, 11'd0);
    cell_queue.push_back(8'hFF);
    cell_queue.push_back(8'hFE);
    drain();

    // All-free 3 x 3: the centre sees all eight neighbours.
    set_grid(11'd3, 11'd3);
    repeat (9) cell_queue.push_back(8'h01);
    drain();

    // Random frames over a spread of geometries and idle patterns.
    run_phase(11'd6,    11'd4,    24, IDLE_NONE, 80);
    run_phase(11'd32,   11'd2,    64, IDLE_SEND, 70);   // widest row: 34 results on the last cell
    run_phase(11'd1,    11'd7,    30, IDLE_RECV, 60);
    run_phase(11'd2,    11'd1,    24, IDLE_BOTH, 50);
    run_phase(11'h7E2,  11'h7FF,  32, IDLE_RECV, 85);   // oversize values clamp to 32 x 1024

    // Back the block up: hold the result side off while cells keep coming.
    set_grid(11'd4, 11'd3);
    idle_mode = IDLE_NONE;
    hold_req  = 1'b1;
    random_cells(48, 75);
    drain();

    run_phase(11'd7,    11'd5,    35, IDLE_BOTH, 40);
    run_phase(11'd3,    11'd2,    12, IDLE_SEND, 90);

    drain();
    $display("tb_top: %0d cells sent, %0d results checked across %0d grid settings",
             cells_sent, results_checked, settings_used);
    $display("tb_top: covered 1-wide to 32-wide rows, clamped sizes and long back-pressure");
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: %0d mismatches", mismatches);
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("tb_top: timeout");
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
